>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies the consequent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/ata48_pkg.sv
package ata48_pkg;

	// field widths
	localparam int BYTES_W = 25;
	localparam int LBA_W = 48;
	localparam int PORT_W = 16;
	localparam int DATA_W = 8;
	localparam int CFG_INDEX_W = 2;

	// sector size, a power of two
	localparam int SECTOR_BYTES = 512;
	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam int COUNT_W = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PRIMARY_BASE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SECONDARY_BASE = 2'd1;

	localparam logic [PORT_W-1:0] PRIMARY_BASE_RST = 16'h01f0;
	localparam logic [PORT_W-1:0] SECONDARY_BASE_RST = 16'h0170;

	// task-file bytes
	localparam logic [DATA_W-1:0] CMD_READ_EXT = 8'h24;
	localparam logic [DATA_W-1:0] CMD_WRITE_EXT = 8'h34;
	localparam logic [DATA_W-1:0] DEVSEL_BASE = 8'he0;
	localparam logic [1:0] NO_DRIVE = 2'd3;

	// task-file register offsets
	localparam logic [2:0] OFS_COUNT = 3'd2;
	localparam logic [2:0] OFS_LBA_LO = 3'd3;
	localparam logic [2:0] OFS_LBA_MID = 3'd4;
	localparam logic [2:0] OFS_LBA_HI = 3'd5;
	localparam logic [2:0] OFS_DEVICE = 3'd6;
	localparam logic [2:0] OFS_COMMAND = 3'd7;

	// write sequence steps
	typedef enum logic [3:0] {
		STEP_DEVSEL,
		STEP_CNT_HI,
		STEP_LBA3,
		STEP_LBA4,
		STEP_LBA5,
		STEP_CNT_LO,
		STEP_LBA0,
		STEP_LBA1,
		STEP_LBA2,
		STEP_CMD
	} step_t;

	// classified command held in the queue
	typedef struct packed {
		logic [PORT_W-1:0] base;
		logic [DATA_W-1:0] cmd;
		logic slave;
		logic need_sel;
		logic [COUNT_W-1:0] count;
		logic [LBA_W-1:0] lba;
		logic [BYTES_W-1:0] xfer;
	} cmd_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/ata48_req_if.sv
interface ata48_req_if import ata48_pkg::*; ();
	logic valid;
	logic ready;
	logic action;
	logic channel;
	logic drive_slave;
	logic [LBA_W-1:0] lba;
	logic [BYTES_W-1:0] byte_count;

	modport source (output valid, action, channel, drive_slave, lba, byte_count, input ready);
	modport sink (input valid, action, channel, drive_slave, lba, byte_count, output ready);
endinterface

>>> rtl/ata48_wr_if.sv
interface ata48_wr_if import ata48_pkg::*; ();
	logic valid;
	logic ready;
	logic [PORT_W-1:0] port_address;
	logic [DATA_W-1:0] data_byte;
	logic [BYTES_W-1:0] transfer_bytes;
	logic last;

	modport source (output valid, port_address, data_byte, transfer_bytes, last, input ready);
	modport sink (input valid, port_address, data_byte, transfer_bytes, last, output ready);
endinterface

>>> rtl/ata48_cfg_if.sv
interface ata48_cfg_if import ata48_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [PORT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ata48_queue.sv
module ata48_queue import ata48_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_entry_t push_entry,
	input logic pop,
	output cmd_entry_t head,
	output q_status_t status
);

	cmd_entry_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head = entry_q[rd_ptr_q];
	assign status.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);

endmodule

>>> rtl/ata48_front.sv
module ata48_front import ata48_pkg::*; (
	input logic clk,
	input logic arst_n,
	ata48_req_if.sink req,
	ata48_cfg_if.sink cfg,
	input q_status_t q_status,
	output logic push,
	output cmd_entry_t push_entry
);

	logic [PORT_W-1:0] primary_base_q;
	logic [PORT_W-1:0] secondary_base_q;
	logic [1:0] sel_q [2];
	logic accept;
	logic [COUNT_W-1:0] count;
	logic need_sel;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_base_q <= PRIMARY_BASE_RST;
			secondary_base_q <= SECONDARY_BASE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PRIMARY_BASE: primary_base_q <= cfg.data;
				REG_SECONDARY_BASE: secondary_base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// classify the request
	assign req.ready = !q_status.full;
	assign accept = req.valid && req.ready;
	assign count = COUNT_W'(req.byte_count >> SECTOR_SHIFT);
	assign need_sel = (sel_q[req.channel] != {1'b0, req.drive_slave});
	assign push = accept && (count != '0);

	always_comb begin
		push_entry.base = req.channel ? secondary_base_q : primary_base_q;
		push_entry.cmd = req.action ? CMD_WRITE_EXT : CMD_READ_EXT;
		push_entry.slave = req.drive_slave;
		push_entry.need_sel = need_sel;
		push_entry.count = count;
		push_entry.lba = req.lba;
		push_entry.xfer = req.byte_count & ~BYTES_W'(SECTOR_BYTES - 1);
	end

	// drive selected on each channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q[0] <= NO_DRIVE;
			sel_q[1] <= NO_DRIVE;
		end else if (push) begin
			sel_q[req.channel] <= {1'b0, req.drive_slave};
		end
	end

endmodule

>>> rtl/ata48_back.sv
module ata48_back import ata48_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_entry_t head,
	input q_status_t q_status,
	output logic pop,
	ata48_wr_if.source wr
);

	step_t step_q;
	step_t step_d;
	step_t cur_step;
	logic in_prog_q;
	logic in_prog_d;
	logic load;
	logic [2:0] offset;
	logic [DATA_W-1:0] data;
	logic [PORT_W-1:0] port_q;
	logic [DATA_W-1:0] data_q;
	logic [BYTES_W-1:0] xfer_q;
	logic last_q;
	logic valid_q;

	// step of the write about to be loaded
	assign cur_step = in_prog_q ? step_q : (head.need_sel ? STEP_DEVSEL : STEP_CNT_HI);
	assign load = !q_status.empty && (!valid_q || wr.ready);
	assign pop = load && (cur_step == STEP_CMD);

	// next step
	always_comb begin
		step_d = step_q;
		in_prog_d = in_prog_q;
		if (load) begin
			in_prog_d = (cur_step != STEP_CMD);
			unique case (cur_step)
				STEP_DEVSEL: step_d = STEP_CNT_HI;
				STEP_CNT_HI: step_d = STEP_LBA3;
				STEP_LBA3: step_d = STEP_LBA4;
				STEP_LBA4: step_d = STEP_LBA5;
				STEP_LBA5: step_d = STEP_CNT_LO;
				STEP_CNT_LO: step_d = STEP_LBA0;
				STEP_LBA0: step_d = STEP_LBA1;
				STEP_LBA1: step_d = STEP_LBA2;
				STEP_LBA2: step_d = STEP_CMD;
				STEP_CMD: step_d = STEP_DEVSEL;
				default: step_d = STEP_DEVSEL;
			endcase
		end
	end

	// register and byte for the current step
	always_comb begin
		unique case (cur_step)
			STEP_DEVSEL: begin
				offset = OFS_DEVICE;
				data = DEVSEL_BASE | {3'b000, head.slave, 4'b0000};
			end
			STEP_CNT_HI: begin
				offset = OFS_COUNT;
				data = head.count[15:8];
			end
			STEP_LBA3: begin
				offset = OFS_LBA_LO;
				data = head.lba[31:24];
			end
			STEP_LBA4: begin
				offset = OFS_LBA_MID;
				data = head.lba[39:32];
			end
			STEP_LBA5: begin
				offset = OFS_LBA_HI;
				data = head.lba[47:40];
			end
			STEP_CNT_LO: begin
				offset = OFS_COUNT;
				data = head.count[7:0];
			end
			STEP_LBA0: begin
				offset = OFS_LBA_LO;
				data = head.lba[7:0];
			end
			STEP_LBA1: begin
				offset = OFS_LBA_MID;
				data = head.lba[15:8];
			end
			STEP_LBA2: begin
				offset = OFS_LBA_HI;
				data = head.lba[23:16];
			end
			STEP_CMD: begin
				offset = OFS_COMMAND;
				data = head.cmd;
			end
			default: begin
				offset = OFS_COMMAND;
				data = head.cmd;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_DEVSEL;
			in_prog_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			in_prog_q <= in_prog_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (wr.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			port_q <= head.base + PORT_W'(offset);
			data_q <= data;
			xfer_q <= head.xfer;
			last_q <= (cur_step == STEP_CMD);
		end
	end

	assign wr.valid = valid_q;
	assign wr.port_address = port_q;
	assign wr.data_byte = data_q;
	assign wr.transfer_bytes = xfer_q;
	assign wr.last = last_q;

endmodule

>>> rtl/ata_lba48_command_issuer.sv
// a request reaches its first register write via the queue and then the output register
// the back-end sequencer issues one task-file write per cycle while a command is queued and
// the write side is ready: a device select only when the drive changes, then count, LBA, command
// requests of zero whole sectors are taken and give no writes
// reset: bases return to 0x1f0 and 0x170, no drive selected, queue and output empty
module ata_lba48_command_issuer import ata48_pkg::*; (
	input logic clk,
	input logic arst_n,
	ata48_req_if.sink req,
	ata48_cfg_if.sink cfg,
	ata48_wr_if.source wr
);

`include "assert_macros.svh"

	logic push;
	logic pop;
	cmd_entry_t push_entry;
	cmd_entry_t head;
	q_status_t q_status;
	logic wr_cmd_byte;
	logic wr_whole_xfer;

	// request classification
	ata48_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg(cfg),
		.q_status(q_status),
		.push(push),
		.push_entry(push_entry)
	);

	// command queue
	ata48_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	// write sequencer
	ata48_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.wr(wr)
	);

	// terms used by the checks
	assign wr_cmd_byte = (wr.data_byte == CMD_READ_EXT) || (wr.data_byte == CMD_WRITE_EXT);
	assign wr_whole_xfer = (wr.transfer_bytes[SECTOR_SHIFT-1:0] == '0)
		&& (wr.transfer_bytes != '0);

	// checks
	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !q_status.full)
	`ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, !q_status.empty)
	`ASSERT_IMPLIES(a_last_is_cmd, clk, arst_n, wr.valid && wr.last, wr_cmd_byte)
	`ASSERT_IMPLIES(a_whole_sectors, clk, arst_n, wr.valid, wr_whole_xfer)
	`ASSERT_NEXT(a_pop_shows_last, clk, arst_n, pop, wr.valid && wr.last)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

import ata48_pkg::*;

// one request as it crosses the request channel
typedef struct packed {
	logic action;
	logic channel;
	logic drive_slave;
	logic [LBA_W-1:0] lba;
	logic [BYTES_W-1:0] byte_count;
} ata_request_t;

// one task-file register write as it leaves the block
typedef struct packed {
	logic [PORT_W-1:0] port_address;
	logic [DATA_W-1:0] data_byte;
	logic [BYTES_W-1:0] transfer_bytes;
	logic last;
} task_file_write_t;

class task_file_scoreboard;
	logic [PORT_W-1:0] primary_base;
	logic [PORT_W-1:0] secondary_base;
	logic [1:0] drive_on_channel [2];
	task_file_write_t expected_writes [$];
	int errors;

	function new();
		primary_base = PRIMARY_BASE_RST;
		secondary_base = SECONDARY_BASE_RST;
		drive_on_channel[0] = NO_DRIVE;
		drive_on_channel[1] = NO_DRIVE;
		errors = 0;
	endfunction

	// register writes to unknown indexes fall through
	function void note_config(logic [CFG_INDEX_W-1:0] index, logic [PORT_W-1:0] value);
		if (index == REG_PRIMARY_BASE) begin
			primary_base = value;
		end else if (index == REG_SECONDARY_BASE) begin
			secondary_base = value;
		end
	endfunction

	function void push_write(logic [PORT_W-1:0] base, logic [2:0] offset,
			logic [DATA_W-1:0] value, logic [BYTES_W-1:0] xfer, logic is_last);
		task_file_write_t w;
		w.port_address = base + {{(PORT_W-3){1'b0}}, offset};
		w.data_byte = value;
		w.transfer_bytes = xfer;
		w.last = is_last;
		expected_writes.push_back(w);
	endfunction

	// work out the register writes that one accepted request causes
	function void note_request(ata_request_t r);
		logic [COUNT_W-1:0] sectors;
		logic [BYTES_W-1:0] xfer;
		logic [PORT_W-1:0] base;
		logic [DATA_W-1:0] command;
		sectors = r.byte_count[BYTES_W-1:SECTOR_SHIFT];
		xfer = {sectors, {SECTOR_SHIFT{1'b0}}};
		base = r.channel ? secondary_base : primary_base;
		command = r.action ? CMD_WRITE_EXT : CMD_READ_EXT;
		if (sectors == '0)
			return;
		// device select only when the drive changes on this channel
		if (drive_on_channel[r.channel] != {1'b0, r.drive_slave}) begin
			push_write(base, OFS_DEVICE, DEVSEL_BASE | {3'b000, r.drive_slave, 4'b0000},
				xfer, 1'b0);
			drive_on_channel[r.channel] = {1'b0, r.drive_slave};
		end
		// high bytes first, then low bytes, then the command
		push_write(base, OFS_COUNT, sectors[15:8], xfer, 1'b0);
		push_write(base, OFS_LBA_LO, r.lba[31:24], xfer, 1'b0);
		push_write(base, OFS_LBA_MID, r.lba[39:32], xfer, 1'b0);
		push_write(base, OFS_LBA_HI, r.lba[47:40], xfer, 1'b0);
		push_write(base, OFS_COUNT, sectors[7:0], xfer, 1'b0);
		push_write(base, OFS_LBA_LO, r.lba[7:0], xfer, 1'b0);
		push_write(base, OFS_LBA_MID, r.lba[15:8], xfer, 1'b0);
		push_write(base, OFS_LBA_HI, r.lba[23:16], xfer, 1'b0);
		push_write(base, OFS_COMMAND, command, xfer, 1'b1);
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_write(task_file_write_t got);
		task_file_write_t want;
		if (expected_writes.size() == 0) begin
			report($sformatf("unexpected write port %h data %h", got.port_address,
				got.data_byte));
			return;
		end
		want = expected_writes.pop_front();
		if (got.port_address !== want.port_address)
			report($sformatf("port_address %h, wanted %h", got.port_address,
				want.port_address));
		if (got.data_byte !== want.data_byte)
			report($sformatf("data_byte %h, wanted %h at port %h", got.data_byte,
				want.data_byte, want.port_address));
		if (got.transfer_bytes !== want.transfer_bytes)
			report($sformatf("transfer_bytes %h, wanted %h", got.transfer_bytes,
				want.transfer_bytes));
		if (got.last !== want.last)
			report($sformatf("last %b, wanted %b at port %h", got.last, want.last,
				want.port_address));
	endtask

	function int pending();
		return expected_writes.size();
	endfunction

	task check_leftovers();
		if (expected_writes.size() != 0)
			report($sformatf("%0d expected writes never arrived", expected_writes.size()));
	endtask
endclass

module testbench;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 34;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	logic clk;
	logic arst_n;
	int cycle_count;
	bit hold_writes;
	bit write_stalls_on;
	bit request_gaps_on;
	task_file_scoreboard sb;

	ata48_req_if req_bus ();
	ata48_cfg_if cfg_bus ();
	ata48_wr_if wr_bus ();

	ata_lba48_command_issuer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.cfg(cfg_bus),
		.wr(wr_bus)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// observe every transfer on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				sb.note_request({req_bus.action, req_bus.channel, req_bus.drive_slave,
					req_bus.lba, req_bus.byte_count});
			if (cfg_bus.valid && cfg_bus.ready)
				sb.note_config(cfg_bus.index, cfg_bus.data);
			if (wr_bus.valid && wr_bus.ready)
				sb.check_write({wr_bus.port_address, wr_bus.data_byte,
					wr_bus.transfer_bytes, wr_bus.last});
		end
	end

	// write receiver: random stall bursts and one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_writes) begin
				wr_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_writes = 1'b0;
			end else if (write_stalls_on && $urandom_range(0, 5) == 0) begin
				wr_bus.ready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				wr_bus.ready <= 1'b1;
			end
		end
	end

	function automatic ata_request_t make_request(logic action, logic channel,
			logic slave, logic [LBA_W-1:0] lba, logic [BYTES_W-1:0] byte_count);
		ata_request_t r;
		r.action = action;
		r.channel = channel;
		r.drive_slave = slave;
		r.lba = lba;
		r.byte_count = byte_count;
		return r;
	endfunction

	function automatic ata_request_t random_request();
		ata_request_t r;
		r.action = 1'($urandom_range(0, 1));
		r.channel = 1'($urandom_range(0, 1));
		r.drive_slave = 1'($urandom_range(0, 1));
		r.lba[47:32] = 16'($urandom_range(0, 65535));
		r.lba[31:0] = $urandom;
		// mostly full-range sizes, some below one sector, some just over
		case ($urandom_range(0, 7))
			0: r.byte_count = BYTES_W'($urandom_range(0, SECTOR_BYTES - 1));
			1: r.byte_count = BYTES_W'($urandom_range(SECTOR_BYTES, 4 * SECTOR_BYTES));
			default: r.byte_count = BYTES_W'($urandom);
		endcase
		return r;
	endfunction

	task automatic offer_request(input ata_request_t r);
		@(negedge clk);
		req_bus.valid <= 1'b1;
		req_bus.action <= r.action;
		req_bus.channel <= r.channel;
		req_bus.drive_slave <= r.drive_slave;
		req_bus.lba <= r.lba;
		req_bus.byte_count <= r.byte_count;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
	endtask

	task automatic idle_requests(input int cycles);
		@(negedge clk);
		req_bus.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// lower the request valid, let all writes out and the block settle
	task automatic quiesce();
		idle_requests(1);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [PORT_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		hold_writes = 1'b0;
		write_stalls_on = 1'b1;
		request_gaps_on = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.action = 1'b0;
		req_bus.channel = 1'b0;
		req_bus.drive_slave = 1'b0;
		req_bus.lba = '0;
		req_bus.byte_count = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		wr_bus.ready = 1'b1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset bases, drive selection and zero-sector cases
		offer_request(make_request(1'b0, 1'b0, 1'b0, 48'h0, 25'd512));
		offer_request(make_request(1'b1, 1'b0, 1'b0, 48'hffff_ffff_ffff, 25'h1ff_ffff));
		offer_request(make_request(1'b0, 1'b1, 1'b1, 48'h0, 25'd0));
		offer_request(make_request(1'b0, 1'b1, 1'b1, 48'h0123_4567_89ab, 25'd511));
		offer_request(make_request(1'b1, 1'b1, 1'b1, 48'haaaa_aaaa_aaaa, 25'h155_5555));
		offer_request(make_request(1'b0, 1'b1, 1'b1, 48'h5555_5555_5555, 25'h0aa_aaaa));
		offer_request(make_request(1'b0, 1'b1, 1'b0, 48'h8000_0000_0001, 25'd1023));
		offer_request(make_request(1'b1, 1'b0, 1'b1, 48'h00ff_00ff_00ff, 25'h1ff_fe00));
		offer_request(make_request(1'b1, 1'b0, 1'b0, 48'h1234_5678_9abc, 25'h020_0000));
		offer_request(make_request(1'b0, 1'b0, 1'b0, 48'hffff_ffff_ffff, 25'd511));
		quiesce();

		// top-end bases so port addresses wrap, plus the spare indexes
		write_reg(REG_PRIMARY_BASE, 16'hffff);
		write_reg(REG_SECONDARY_BASE, 16'hfffa);
		write_reg(REG_SPARE_LO, 16'h1234);
		write_reg(REG_SPARE_HI, 16'hffff);
		offer_request(make_request(1'b0, 1'b0, 1'b0, 48'h0000_0000_0001, 25'd1024));
		offer_request(make_request(1'b1, 1'b1, 1'b1, 48'hfedc_ba98_7654, 25'd4096));
		offer_request(make_request(1'b1, 1'b0, 1'b1, 48'h0000_ffff_0000, 25'h100_0000));
		quiesce();

		// zero bases
		write_reg(REG_PRIMARY_BASE, 16'h0000);
		write_reg(REG_SECONDARY_BASE, 16'h0000);
		offer_request(make_request(1'b0, 1'b0, 1'b0, 48'hffff_0000_ffff, 25'h000_0200));
		offer_request(make_request(1'b1, 1'b1, 1'b0, 48'h7fff_ffff_ffff, 25'h0ff_ffff));
		quiesce();

		// random phases, each under its own base settings
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				write_reg(REG_PRIMARY_BASE, PRIMARY_BASE_RST);
				write_reg(REG_SECONDARY_BASE, SECONDARY_BASE_RST);
			end else begin
				write_reg(REG_PRIMARY_BASE, PORT_W'($urandom_range(0, 65535)));
				write_reg(REG_SECONDARY_BASE, PORT_W'($urandom_range(0, 65535)));
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					PORT_W'($urandom_range(0, 65535)));
			end
			request_gaps_on = (phase != PHASES - 1);
			write_stalls_on = (phase != PHASES - 1);
			// long hold-off on the write side while requests keep coming
			if (phase == 2)
				hold_writes = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 1 && i == PHASE_ITEMS / 2) begin
					idle_requests(1);
					wait_drained();
				end
				if (request_gaps_on && !(phase == 2 && i < 12) && $urandom_range(0, 4) == 0)
					idle_requests($urandom_range(1, 14));
				offer_request(random_request());
			end
			quiesce();
		end

		repeat (20) @(posedge clk);
		sb.check_leftovers();
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

>>> ata_lba48_command_issuer.f
+incdir+rtl
rtl/ata48_pkg.sv
rtl/ata48_req_if.sv
rtl/ata48_wr_if.sv
rtl/ata48_cfg_if.sv
rtl/ata48_queue.sv
rtl/ata48_front.sv
rtl/ata48_back.sv
rtl/ata_lba48_command_issuer.sv
verif/testbench.sv
